FILE: hw/rtl/vtsr_pkg.sv
// Shared types and constants for the velocity to stick ratio block.
// Holds field widths, the fixed map constants, and the command struct
// that the controller sends to the datapath. No dependencies.
package vtsr_pkg;

  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned STICK_W    = 8;
  localparam int unsigned RAD_W      = 10;
  localparam int unsigned TREAD_W    = 11;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned STEP_W     = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TREAD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd3;

  localparam logic [RAD_W-1:0]    RADIUS_RST = 10'd300;
  localparam logic [TREAD_W-1:0]  TREAD_RST  = 11'd500;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd0;
  localparam logic [STEP_W-1:0]   STEP_RST   = 8'd0;

  // Datapath widths, sized for the largest register settings.
  localparam int unsigned MAG_W     = SPEED_W + 1;
  localparam int unsigned MUL_A_W   = 56;
  localparam int unsigned MUL_B_W   = 11;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned D_W       = 45;
  localparam int unsigned THR_W     = 50;
  localparam int unsigned DEN_W     = 54;
  localparam int unsigned X_W       = MUL_A_W;
  localparam int unsigned NUM_W     = 64;
  localparam int unsigned Q_W       = 8;
  localparam int unsigned DIV_CNT_W = $clog2(Q_W);
  localparam int unsigned X_SHIFT   = 18;

  // Pi in Q2.30.
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  // Speed scale 758400 = 1896 * 400; the turn scale is 1896 * tread.
  localparam logic [MUL_B_W-1:0] K_SPEED     = 11'd1896;
  localparam logic [MUL_B_W-1:0] K_FWD_SCALE = 11'd400;
  localparam logic [MUL_B_W-1:0] K_DA        = 11'd5;

  localparam logic [MUL_B_W-1:0] RPM_FWD_MIN   = 11'd20;
  localparam logic [MUL_B_W-1:0] RPM_REV_MIN   = 11'd15;
  localparam logic [MUL_B_W-1:0] RPM_TURN_MIN  = 11'd20;
  localparam logic [MUL_B_W-1:0] RPM_FWD_SPAN  = 11'd1660;
  localparam logic [MUL_B_W-1:0] RPM_REV_SPAN  = 11'd800;
  localparam logic [MUL_B_W-1:0] RPM_TURN_SPAN = 11'd300;

  localparam logic [MUL_B_W-1:0] RATIO_FWD_SPAN  = 11'd97;
  localparam logic [MUL_B_W-1:0] RATIO_REV_SPAN  = 11'd95;
  localparam logic [MUL_B_W-1:0] RATIO_TURN_SPAN = 11'd86;

  localparam logic [STICK_W-1:0] RATIO_FWD_MIN  = 8'd3;
  localparam logic [STICK_W-1:0] RATIO_REV_MIN  = 8'd5;
  localparam logic [STICK_W-1:0] RATIO_TURN_MIN = 8'd14;
  localparam logic [STICK_W-1:0] RATIO_MAX      = 8'd100;

  typedef enum logic [3:0] {
    OP_IDLE  = 4'd0,
    OP_LOAD  = 4'd1,
    OP_DT    = 4'd2,
    OP_DA    = 4'd3,
    OP_THR   = 4'd4,
    OP_DEN   = 4'd5,
    OP_P     = 4'd6,
    OP_X     = 4'd7,
    OP_NUM   = 4'd8,
    OP_DINIT = 4'd9,
    OP_DSTEP = 4'd10,
    OP_FIN   = 4'd11,
    OP_NUDGE = 4'd12
  } vtsr_op_t;

  typedef struct packed {
    vtsr_op_t               op;
    logic                   turn;
    logic [DIV_CNT_W-1:0]   bit_idx;
  } vtsr_cmd_t;

  typedef struct packed {
    logic [RAD_W-1:0]    radius;
    logic [TREAD_W-1:0]  tread;
    logic [PERIOD_W-1:0] period;
    logic [STEP_W-1:0]   step;
  } vtsr_cfg_t;

endpackage

FILE: hw/rtl/velocity_to_stick_ratio.sv
// Velocity to stick ratio converter, top level.
// Holds the configuration registers and joins vtsr_ctrl and vtsr_dp.
// Depends on vtsr_pkg.
//
// Usage: an input transaction carries a forward speed and a turn rate, both
// signed Q4.12, on a valid/ready channel. Each accepted transaction yields
// exactly one result transaction with the forward and turn stick ratios,
// each in -100..100, on a second valid/ready channel.
// A new transaction is accepted only once the sequencer has returned to
// idle. The work is done by the single shared 56x11 multiplier, used
// six times per lane, and the eight-step restoring divider that forms
// each lane's quotient.
// The result sits in an output register; the block accepts the next
// transaction while it waits. If the receiver stalls, processing halts just
// before the output register and resumes when the held result is taken.
// The user must make configuration writes only while idle; the block does
// not enforce it. Reset (synchronous, active low) clears the sequencer, the
// output valid and the nudge counter and reloads the registers' defaults.
module velocity_to_stick_ratio (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [vtsr_pkg::SPEED_W-1:0]   in_forward_speed,
  input  logic signed [vtsr_pkg::SPEED_W-1:0]   in_turn_rate,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [vtsr_pkg::STICK_W-1:0]   out_forward_stick,
  output logic signed [vtsr_pkg::STICK_W-1:0]   out_turn_stick,
  input  logic                                  cfg_we,
  input  logic [vtsr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vtsr_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import vtsr_pkg::*;

  vtsr_cfg_t cfg_r, cfg_nxt;
  vtsr_cmd_t cmd;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIUS: cfg_nxt.radius = cfg_data[RAD_W-1:0];
        CFG_TREAD:  cfg_nxt.tread  = cfg_data[TREAD_W-1:0];
        CFG_PERIOD: cfg_nxt.period = cfg_data[PERIOD_W-1:0];
        CFG_STEP:   cfg_nxt.step   = cfg_data[STEP_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius <= RADIUS_RST;
      cfg_r.tread  <= TREAD_RST;
      cfg_r.period <= PERIOD_RST;
      cfg_r.step   <= STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  vtsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  vtsr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg               (cfg_r),
    .in_forward_speed  (in_forward_speed),
    .in_turn_rate      (in_turn_rate),
    .out_forward_stick (out_forward_stick),
    .out_turn_stick    (out_turn_stick)
  );

endmodule

FILE: hw/rtl/vtsr_ctrl.sv
// Sequencer for the velocity to stick ratio block.
// Walks the forward lane then the turn lane through the shared datapath.
// Depends on vtsr_pkg.
module vtsr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output vtsr_pkg::vtsr_cmd_t cmd
);
  import vtsr_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_DT    = 12'b0000_0000_0010,
    S_DA    = 12'b0000_0000_0100,
    S_THR   = 12'b0000_0000_1000,
    S_DEN   = 12'b0000_0001_0000,
    S_P     = 12'b0000_0010_0000,
    S_X     = 12'b0000_0100_0000,
    S_NUM   = 12'b0000_1000_0000,
    S_DINIT = 12'b0001_0000_0000,
    S_DSTEP = 12'b0010_0000_0000,
    S_FIN   = 12'b0100_0000_0000,
    S_NUDGE = 12'b1000_0000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic                 lane_r, lane_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    lane_nxt      = lane_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_IDLE;
    cmd.turn      = lane_r;
    cmd.bit_idx   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          lane_nxt  = 1'b0;
          state_nxt = S_DT;
        end
      end
      S_DT: begin
        cmd.op    = OP_DT;
        state_nxt = S_THR;
      end
      S_DA: begin
        cmd.op    = OP_DA;
        state_nxt = S_THR;
      end
      S_THR: begin
        cmd.op    = OP_THR;
        state_nxt = S_DEN;
      end
      S_DEN: begin
        cmd.op    = OP_DEN;
        state_nxt = S_P;
      end
      S_P: begin
        cmd.op    = OP_P;
        state_nxt = S_X;
      end
      S_X: begin
        cmd.op    = OP_X;
        state_nxt = S_NUM;
      end
      S_NUM: begin
        cmd.op    = OP_NUM;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.op    = OP_DINIT;
        cnt_nxt   = DIV_CNT_W'(Q_W - 1);
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op = OP_DSTEP;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_FIN: begin
        cmd.op = OP_FIN;
        if (lane_r) begin
          state_nxt = S_NUDGE;
        end else begin
          lane_nxt  = 1'b1;
          state_nxt = S_DA;
        end
      end
      S_NUDGE: begin
        // The final stage writes the output register, so wait for it to drain.
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_NUDGE;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lane_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lane_r      <= lane_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DSTEP && cnt_r == '0) |=> (state_r == S_FIN))
    else $error("divider did not hand over to the finish step");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DT && !lane_r))
    else $error("accepted transaction did not start the forward lane");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_NUDGE))
    else $error("result presented without passing the final stage");

endmodule

FILE: hw/rtl/vtsr_dp.sv
// Datapath for the velocity to stick ratio block: one shared multiplier,
// a restoring divider for the ratio quotient, and the nudge counter.
// Depends on vtsr_pkg; driven by vtsr_ctrl commands.
module vtsr_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vtsr_pkg::vtsr_cmd_t                 cmd,
  input  vtsr_pkg::vtsr_cfg_t                 cfg,
  input  logic signed [vtsr_pkg::SPEED_W-1:0] in_forward_speed,
  input  logic signed [vtsr_pkg::SPEED_W-1:0] in_turn_rate,
  output logic signed [vtsr_pkg::STICK_W-1:0] out_forward_stick,
  output logic signed [vtsr_pkg::STICK_W-1:0] out_turn_stick
);
  import vtsr_pkg::*;

  logic [MAG_W-1:0]   fs_ext, tr_ext, fmag, tmag;
  logic               fneg_r, tneg_r;
  logic [MAG_W-1:0]   fmag_r, tmag_r;
  logic [D_W-1:0]     d_r;
  logic [THR_W-1:0]   thr_r;
  logic [DEN_W-1:0]   den_r;
  logic [X_W-1:0]     x_r;
  logic [NUM_W-1:0]   num_r, rem_r, dsub;
  logic [Q_W-1:0]     q_r;
  logic               zero_r, sat_r;
  logic [STICK_W-1:0] fwd_r, trat_r;
  logic [STICK_W-1:0] out_fwd_r;
  logic signed [STICK_W-1:0] out_turn_r;
  logic [PERIOD_W-1:0] count_r, count_nxt;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  logic               neg_sel;
  logic [STICK_W-1:0] min_sel, mag;
  logic [STICK_W:0]   sum;
  logic [STICK_W-1:0] ratio;

  logic               period_on, fire;
  logic signed [STICK_W:0]   turn_sum;
  logic signed [STICK_W-1:0] turn_clamp;

  assign fs_ext = {in_forward_speed[SPEED_W-1], in_forward_speed};
  assign tr_ext = {in_turn_rate[SPEED_W-1], in_turn_rate};
  assign fmag   = in_forward_speed[SPEED_W-1] ? (~fs_ext + 1'b1) : fs_ext;
  assign tmag   = in_turn_rate[SPEED_W-1] ? (~tr_ext + 1'b1) : tr_ext;

  assign neg_sel = cmd.turn ? tneg_r : fneg_r;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_DT: begin
        mul_a = MUL_A_W'(PI_Q30);
        mul_b = MUL_B_W'(cfg.radius);
      end
      OP_DA: begin
        mul_a = MUL_A_W'(d_r);
        mul_b = K_DA;
      end
      OP_THR: begin
        mul_a = MUL_A_W'(d_r);
        mul_b = cmd.turn ? RPM_TURN_MIN : (fneg_r ? RPM_REV_MIN : RPM_FWD_MIN);
      end
      OP_DEN: begin
        mul_a = MUL_A_W'(d_r);
        mul_b = cmd.turn ? RPM_TURN_SPAN : (fneg_r ? RPM_REV_SPAN : RPM_FWD_SPAN);
      end
      OP_P: begin
        mul_a = MUL_A_W'(cmd.turn ? tmag_r : fmag_r);
        mul_b = K_SPEED;
      end
      OP_X: begin
        mul_a = x_r;
        mul_b = cmd.turn ? cfg.tread : K_FWD_SCALE;
      end
      OP_NUM: begin
        // Wraps when the magnitude sits below the dead zone; zero_r masks it.
        mul_a = x_r - X_W'(thr_r);
        mul_b = cmd.turn ? RATIO_TURN_SPAN :
                (fneg_r ? RATIO_REV_SPAN : RATIO_FWD_SPAN);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign dsub = NUM_W'(den_r) << cmd.bit_idx;

  // Ratio of the current lane from the quotient.
  assign min_sel = cmd.turn ? RATIO_TURN_MIN : (fneg_r ? RATIO_REV_MIN : RATIO_FWD_MIN);
  assign sum     = {1'b0, min_sel} + {1'b0, q_r};
  always_comb begin
    priority if (zero_r) begin
      mag = '0;
    end else if (sat_r || sum > {1'b0, RATIO_MAX}) begin
      mag = RATIO_MAX;
    end else begin
      mag = sum[STICK_W-1:0];
    end
  end
  assign ratio = neg_sel ? (~mag + 1'b1) : mag;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        fneg_r <= in_forward_speed[SPEED_W-1];
        tneg_r <= in_turn_rate[SPEED_W-1];
        fmag_r <= fmag;
        tmag_r <= tmag;
      end
      OP_DT, OP_DA: d_r <= prod[D_W-1:0];
      OP_THR:       thr_r <= prod[THR_W-1:0];
      OP_DEN:       den_r <= prod[DEN_W-1:0];
      OP_P:         x_r <= prod[X_W-1:0];
      OP_X:         x_r <= {prod[X_W-X_SHIFT-1:0], {X_SHIFT{1'b0}}};
      OP_NUM: begin
        num_r  <= prod[NUM_W-1:0];
        zero_r <= (x_r <= X_W'(thr_r));
      end
      OP_DINIT: begin
        rem_r <= num_r;
        q_r   <= '0;
        // Quotients of 256 and up all end at the top of the range.
        sat_r <= (num_r >= (NUM_W'(den_r) << Q_W));
      end
      OP_DSTEP: begin
        if (rem_r >= dsub) begin
          rem_r            <= rem_r - dsub;
          q_r[cmd.bit_idx] <= 1'b1;
        end
      end
      OP_FIN: begin
        if (cmd.turn) begin
          trat_r <= ratio;
        end else begin
          fwd_r <= ratio;
        end
      end
      OP_NUDGE: begin
        out_fwd_r  <= fwd_r;
        out_turn_r <= turn_clamp;
      end
      default: begin
      end
    endcase
  end

  // Turn nudge: fires only on a zero turn ratio while moving.
  assign period_on = (cfg.period != '0);
  assign fire      = period_on && (count_r >= cfg.period) &&
                     (trat_r == '0) && (fwd_r != '0);
  assign turn_sum  = $signed({trat_r[STICK_W-1], trat_r}) +
                     (fire ? $signed({cfg.step[STEP_W-1], cfg.step}) : '0);

  always_comb begin
    priority if (turn_sum > $signed({1'b0, RATIO_MAX})) begin
      turn_clamp = $signed(RATIO_MAX);
    end else if (turn_sum < -$signed({1'b0, RATIO_MAX})) begin
      turn_clamp = $signed(~RATIO_MAX + 1'b1);
    end else begin
      turn_clamp = turn_sum[STICK_W-1:0];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.op == OP_NUDGE && period_on) begin
      if (fire) begin
        count_nxt = '0;
      end else if (count_r != '1) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign out_forward_stick = $signed(out_fwd_r);
  assign out_turn_stick    = out_turn_r;

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_NUDGE && cfg.period == '0) |=> $stable(count_r))
    else $error("nudge counter moved while correction is disabled");

  a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.op == OP_NUDGE) |->
      (out_turn_r <= 8'sd100 && out_turn_r >= -8'sd100))
    else $error("turn stick outside the clamp range");

  a_fwd_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.op == OP_NUDGE) |->
      ($signed(out_fwd_r) <= 8'sd100 && $signed(out_fwd_r) >= -8'sd100))
    else $error("forward stick outside the clamp range");

endmodule
